// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/rmpc_pkg.sv =====
package rmpc_pkg;

  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_SAVE  = 2'd1;
  localparam logic [1:0] CMD_TAKE  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd30;
  localparam int          SLOT_W        = 5;

  typedef struct packed {
    logic        valid;
    logic [31:0] msg;
    logic [15:0] src;
    logic [31:0] stamp;
  } entry_t;

endpackage

// ===== rtl/core/message_return_path_cache_core.sv =====
// Result: the result strobe done follows a scan of the entry memory that ends at a hit, at a free
// entry for a save, or at the last entry, then a write-back state; an unused command raises done
// in the cycle after acceptance.
// Order: the entry memory is read one entry per cycle; a new command is taken only once the
// write-back state is over (busy low). The receiver cannot stall.
// Reset: synchronous; a clearing pass empties the memory, busy stays high.
module message_return_path_cache_core
  import rmpc_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic [31:0]       msg_id,
  input  logic [15:0]       source_id,
  input  logic [31:0]       current_time,
  input  logic              timeout_we,
  input  logic [15:0]       timeout_seconds,
  output logic              done,
  output logic              found,
  output logic [15:0]       return_source,
  output logic [SLOT_W-1:0] slot_written
);

  localparam int            AW   = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_SCAN, S_WRB} state_t;

  state_t        state;
  logic [AW-1:0] idx;
  logic          issued_all;
  logic          cmp_vld;
  logic [AW-1:0] cmp_idx;
  logic [1:0]    cmd_q;
  logic [31:0]   id_q;
  logic [15:0]   src_q;
  logic [31:0]   now_q;
  logic [15:0]   timeout_limit;
  logic [31:0]   old_stamp;
  logic [AW-1:0] old_idx;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [$bits(entry_t)-1:0] mem_wdata;
  logic [$bits(entry_t)-1:0] mem_rdata;
  entry_t                    rd_ent;
  entry_t                    save_ent;
  entry_t                    take_ent;
  entry_t                    clr_ent;
  logic [31:0]               age;
  logic                      hit;
  logic                      free;
  logic                      older;
  logic                      is_last;

  rmpc_mem #(
    .DEPTH(ENTRIES),
    .WIDTH($bits(entry_t))
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx),
    .rdata (mem_rdata)
  );

  always_comb begin
    rd_ent         = entry_t'(mem_rdata);
    save_ent.valid = 1'b1;
    save_ent.msg   = id_q;
    save_ent.src   = src_q;
    save_ent.stamp = now_q;
    take_ent       = rd_ent;
    take_ent.valid = 1'b0;
    clr_ent        = '0;
    age            = now_q - rd_ent.stamp;
    hit            = rd_ent.valid && (rd_ent.msg == id_q);
    free           = !rd_ent.valid || (age > {16'b0, timeout_limit});
    older          = (cmp_idx == '0) || (rd_ent.stamp < old_stamp);
    is_last        = (cmp_idx == LAST);
    mem_we         = (state == S_CLR) || ((state == S_WRB) && wr_en);
    mem_waddr      = (state == S_CLR) ? idx : wr_addr;
    mem_wdata      = (state == S_CLR) ? clr_ent : wr_data;
    busy           = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      idx           <= '0;
      issued_all    <= 1'b0;
      cmp_vld       <= 1'b0;
      wr_en         <= 1'b0;
      done          <= 1'b0;
      timeout_limit <= TIMEOUT_RESET;
    end else begin
      if (timeout_we) begin
        timeout_limit <= timeout_seconds;
      end
      unique case (state)
        S_CLR: begin
          if (idx == LAST) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_q      <= command;
            id_q       <= msg_id;
            src_q      <= source_id;
            now_q      <= current_time;
            idx        <= '0;
            issued_all <= 1'b0;
            cmp_vld    <= 1'b0;
            wr_en      <= 1'b0;
            if (command == CMD_NONE) begin
              done          <= 1'b1;
              found         <= 1'b0;
              return_source <= '0;
              slot_written  <= '0;
              state         <= S_WRB;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // advance the read pointer, one entry per cycle
          cmp_vld <= !issued_all;
          cmp_idx <= idx;
          if (!issued_all) begin
            idx <= idx + 1'b1;
            if (idx == LAST) begin
              issued_all <= 1'b1;
            end
          end
          if (cmp_vld) begin
            if (cmd_q == CMD_SAVE) begin
              if (free || is_last) begin
                done          <= 1'b1;
                found         <= 1'b0;
                return_source <= '0;
                wr_en         <= 1'b1;
                wr_data       <= save_ent;
                state         <= S_WRB;
                if (free || older) begin
                  wr_addr      <= cmp_idx;
                  slot_written <= SLOT_W'(cmp_idx);
                end else begin
                  wr_addr      <= old_idx;
                  slot_written <= SLOT_W'(old_idx);
                end
              end else if (older) begin
                old_stamp <= rd_ent.stamp;
                old_idx   <= cmp_idx;
              end
            end else if (hit) begin
              done          <= 1'b1;
              found         <= 1'b1;
              slot_written  <= '0;
              state         <= S_WRB;
              if (cmd_q == CMD_TAKE) begin
                return_source <= rd_ent.src;
                wr_en         <= 1'b1;
                wr_addr       <= cmp_idx;
                wr_data       <= take_ent;
              end else begin
                return_source <= '0;
              end
            end else if (is_last) begin
              done          <= 1'b1;
              found         <= 1'b0;
              return_source <= '0;
              slot_written  <= '0;
              state         <= S_WRB;
            end
          end
        end
        S_WRB: begin
          done  <= 1'b0;
          wr_en <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/rmpc_mem.sv =====
module rmpc_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 81
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rmpc_checker.sv =====
`include "assert_macros.svh"

module rmpc_assertions (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        found,
  input logic [15:0] return_source,
  input logic [4:0]  slot_written
);

  `CHK_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `CHK_NEXT(a_done_single, clk, rst, done, !done && !busy)
  `CHK_NOW(a_src_needs_found, clk, rst, done && (return_source != 16'd0), found)
  `CHK_NOW(a_found_no_slot, clk, rst, done && found, slot_written == 5'd0)

endmodule

bind message_return_path_cache_core rmpc_assertions u_rmpc_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .found         (found),
  .return_source (return_source),
  .slot_written  (slot_written)
);

// ===== dv/rmpc_checker.sv =====
`timescale 1ns / 1ps
module rmpc_checker
  import rmpc_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        command,
  input  logic [31:0]       msg_id,
  input  logic [15:0]       source_id,
  input  logic [31:0]       current_time,
  input  logic              timeout_we,
  input  logic [15:0]       timeout_seconds,
  input  logic              done,
  input  logic              found,
  input  logic [15:0]       return_source,
  input  logic [SLOT_W-1:0] slot_written,
  output int                fails,
  output int                pending
);

  typedef struct packed {
    logic              found;
    logic [15:0]       src;
    logic [SLOT_W-1:0] slot;
  } reply_t;

  logic [31:0] tbl_msg   [ENTRIES];
  logic [15:0] tbl_src   [ENTRIES];
  logic [31:0] tbl_stamp [ENTRIES];
  logic        tbl_live  [ENTRIES];
  logic [15:0] age_limit;
  reply_t      reply_q[$];

  initial begin
    fails   = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    if (fails < 40) begin
      $display("%0t ERROR: %s", $time, msg);
    end
    fails++;
  endtask

  function automatic int lookup_id(input logic [31:0] id);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (tbl_live[i] && tbl_msg[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int pick_victim(input logic [31:0] now);
    int i;
    int oldest;
    logic [31:0] age;
    oldest = 0;
    for (i = 0; i < ENTRIES; i++) begin
      age = now - tbl_stamp[i];
      if (!tbl_live[i] || age > {16'd0, age_limit}) return i;
      if (tbl_stamp[i] < tbl_stamp[oldest]) oldest = i;
    end
    return oldest;
  endfunction

  function automatic reply_t serve(input logic [1:0] cmd, input logic [31:0] id,
                                   input logic [15:0] src, input logic [31:0] now);
    reply_t r;
    int     k;
    r = '0;
    case (cmd)
      CMD_CHECK: begin
        r.found = (lookup_id(id) >= 0);
      end
      CMD_SAVE: begin
        k = pick_victim(now);
        tbl_msg[k]   = id;
        tbl_src[k]   = src;
        tbl_stamp[k] = now;
        tbl_live[k]  = 1'b1;
        r.slot       = k[SLOT_W-1:0];
      end
      CMD_TAKE: begin
        k = lookup_id(id);
        if (k >= 0) begin
          r.found     = 1'b1;
          r.src       = tbl_src[k];
          tbl_live[k] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    int     i;
    if (rst) begin
      for (i = 0; i < ENTRIES; i++) begin
        tbl_msg[i]   = '0;
        tbl_src[i]   = '0;
        tbl_stamp[i] = '0;
        tbl_live[i]  = 1'b0;
      end
      age_limit = TIMEOUT_RESET;
      reply_q.delete();
    end else begin
      if (done) begin
        if (reply_q.size() == 0) begin
          report("result strobe with no item outstanding");
        end else begin
          want = reply_q.pop_front();
          if (found !== want.found)
            report($sformatf("found got %0b want %0b", found, want.found));
          if (return_source !== want.src)
            report($sformatf("return_source got %h want %h", return_source, want.src));
          if (slot_written !== want.slot)
            report($sformatf("slot_written got %0d want %0d", slot_written, want.slot));
        end
      end
      if (start && !busy) begin
        reply_q.push_back(serve(command, msg_id, source_id, current_time));
      end
      if (timeout_we) age_limit = timeout_seconds;
    end
    pending <= reply_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top
  import rmpc_pkg::*;
();

  localparam int ENTRIES     = 32;
  localparam int IDLE_LIMIT  = 1000;
  localparam int PHASE_ITEMS = 250;

  logic              clk             = 1'b0;
  logic              rst             = 1'b1;
  logic              start           = 1'b0;
  logic [1:0]        command         = CMD_CHECK;
  logic [31:0]       msg_id          = '0;
  logic [15:0]       source_id       = '0;
  logic [31:0]       current_time    = '0;
  logic              timeout_we      = 1'b0;
  logic [15:0]       timeout_seconds = TIMEOUT_RESET;
  logic              busy;
  logic              done;
  logic              found;
  logic [15:0]       return_source;
  logic [SLOT_W-1:0] slot_written;
  int                fails;
  int                pending;

  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [31:0] clock_now = '0;
  logic [31:0] id_pool[$];

  always #5 clk = ~clk;

  message_return_path_cache_core #(.ENTRIES(ENTRIES)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .msg_id(msg_id), .source_id(source_id), .current_time(current_time),
    .timeout_we(timeout_we), .timeout_seconds(timeout_seconds), .done(done),
    .found(found), .return_source(return_source), .slot_written(slot_written)
  );

  rmpc_checker #(.ENTRIES(ENTRIES)) chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .msg_id(msg_id), .source_id(source_id), .current_time(current_time),
    .timeout_we(timeout_we), .timeout_seconds(timeout_seconds), .done(done),
    .found(found), .return_source(return_source), .slot_written(slot_written),
    .fails(fails), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || timeout_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue(input logic [1:0] cmd, input logic [31:0] id,
                       input logic [15:0] src, input logic [31:0] tm);
    start        <= 1'b1;
    command      <= cmd;
    msg_id       <= id;
    source_id    <= src;
    current_time <= tm;
    do @(posedge clk); while (busy);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(45, 1)) @(posedge clk);
      burst_left = $urandom_range(24, 1);
    end else begin
      burst_left--;
    end
  endtask

  task automatic set_timeout(input logic [15:0] v);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
    timeout_we      <= 1'b1;
    timeout_seconds <= v;
    @(posedge clk);
    timeout_we <= 1'b0;
  endtask

  task automatic random_item(input int step);
    logic [1:0]  cmd;
    logic [31:0] id;
    logic [15:0] src;
    logic [31:0] tm;
    int          r;
    r = $urandom_range(99);
    if (r < 45) cmd = CMD_SAVE;
    else if (r < 70) cmd = CMD_CHECK;
    else if (r < 95) cmd = CMD_TAKE;
    else cmd = CMD_NONE;
    id = $urandom();
    if (id_pool.size() > 0 &&
        ((cmd != CMD_SAVE && $urandom_range(3) != 0) ||
         (cmd == CMD_SAVE && $urandom_range(9) == 0)))
      id = id_pool[$urandom_range(id_pool.size() - 1)];
    src = 16'($urandom());
    case ($urandom_range(19))
      0: src = 16'hFFFF;
      1: src = 16'h0000;
      default: ;
    endcase
    clock_now += $urandom_range(step);
    tm = clock_now;
    r = $urandom_range(19);
    if (r == 0) tm = $urandom();
    else if (r == 1) tm = clock_now - $urandom_range(step * 4 + 3);
    if (cmd == CMD_SAVE) begin
      id_pool.push_back(id);
      if (id_pool.size() > 40) void'(id_pool.pop_front());
    end
    issue(cmd, id, src, tm);
  endtask

  initial begin
    int          p;
    int          n;
    int          step;
    logic [15:0] lim;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy);

    issue(CMD_CHECK, 32'h0, 16'h0, 32'h0);
    issue(CMD_TAKE, 32'h0, 16'h0, 32'h0);
    issue(CMD_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    issue(CMD_SAVE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    issue(CMD_SAVE, 32'h0, 16'h0, 32'h0);
    issue(CMD_CHECK, 32'hFFFF_FFFF, 16'h5A5A, 32'h0);
    issue(CMD_SAVE, 32'h0, 16'h1234, 32'd5);
    issue(CMD_CHECK, 32'h0, 16'h0, 32'd5);
    issue(CMD_TAKE, 32'h0, 16'hABCD, 32'd5);
    issue(CMD_TAKE, 32'h0, 16'h0, 32'd6);
    issue(CMD_TAKE, 32'h0, 16'h0, 32'd6);
    issue(CMD_SAVE, 32'hA5A5_5A5A, 16'h8001, 32'd100);
    issue(CMD_TAKE, 32'hFFFF_FFFF, 16'h0, 32'd100);
    issue(CMD_TAKE, 32'hA5A5_5A5A, 16'h0, 32'd101);
    issue(CMD_SAVE, 32'h1, 16'h7FFF, 32'd130);
    issue(CMD_SAVE, 32'h2, 16'hFFFF, 32'd131);
    issue(CMD_SAVE, 32'h3, 16'h0001, 32'd140);
    issue(CMD_CHECK, 32'h2, 16'h0, 32'd140);
    issue(CMD_NONE, 32'h0, 16'h0, 32'h0);
    clock_now = 32'd140;

    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin
          lim  = 16'd30;
          step = 1;
        end
        1: begin
          lim  = 16'd0;
          step = 1;
        end
        2: begin
          lim  = 16'hFFFF;
          step = 3000;
        end
        3: begin
          lim  = 16'($urandom_range(65535));
          step = $urandom_range(lim / 8 + 1);
        end
        default: begin
          lim       = 16'd1000;
          step      = 40;
          clock_now = 32'hFFFF_FC00;
        end
      endcase
      set_timeout(lim);
      for (n = 0; n < PHASE_ITEMS; n++) random_item(step);
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (ENTRIES + 5) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
